@@ hw/rtl/ffpa_pkg.sv @@
package ffpa_pkg;

  localparam int COUNT_W    = 11;
  localparam int FPAGE_W    = 10;
  localparam int START_W    = 10;
  localparam int RELEASED_W = 11;
  localparam int STATUS_W   = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPC = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] RES_ALLOC_OK = 2'd0;
  localparam logic [1:0] RES_NOSPC    = 2'd1;
  localparam logic [1:0] RES_ZERO     = 2'd2;
  localparam logic [1:0] RES_FREE     = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       scan;
    logic       len_rd;
    logic       len_take;
    logic       mark;
    logic       mark_val;
    logic       result;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic too_big;
    logic fpage_bad;
    logic clr_last;
    logic found;
    logic scan_end;
    logic len_zero;
    logic wlast;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/ffpa_datapath.sv @@
module ffpa_datapath
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  in_action,
  input  logic [COUNT_W-1:0]    in_count,
  input  logic [FPAGE_W-1:0]    in_fpage,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [START_W-1:0]    out_start,
  output logic [RELEASED_W-1:0] out_released
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  logic                  bm_mem [NUM_PAGES];
  logic [COUNT_W-1:0]    len_mem [NUM_PAGES];

  logic                  req_action_r;
  logic [COUNT_W-1:0]    req_count_r;
  logic [FPAGE_W-1:0]    req_fpage_r;
  logic [CW-1:0]         addr_r;
  logic                  rd_v_r;
  logic [PW-1:0]         rd_pg_r;
  logic                  bm_q_r;
  logic [COUNT_W-1:0]    len_q_r;
  logic [CW-1:0]         run_r;
  logic [PW-1:0]         run_start_r;
  logic [PW-1:0]         at_r;
  logic [PW-1:0]         wp_r;
  logic [COUNT_W-1:0]    wcnt_r;
  logic [COUNT_W-1:0]    len_r;
  logic                  out_tvalid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [START_W-1:0]    out_start_r;
  logic [RELEASED_W-1:0] out_released_r;

  logic          addr_in_heap;
  logic          rd_issue;
  logic [CW-1:0] run_inc;
  logic          hit;
  logic [PW-1:0] found_at;
  logic [PW-1:0] fpage_idx;

  logic               bm_we;
  logic [PW-1:0]      bm_waddr;
  logic               bm_wdata;
  logic               len_we;
  logic [PW-1:0]      len_waddr;
  logic [COUNT_W-1:0] len_wdata;

  assign addr_in_heap = addr_r < CW'(NUM_PAGES);
  assign rd_issue     = cmd.scan && addr_in_heap;
  assign run_inc      = run_r + CW'(1);
  assign hit          = rd_v_r && !bm_q_r && (EW'(run_inc) >= EW'(req_count_r));
  assign found_at     = (run_r == '0) ? rd_pg_r : run_start_r;
  assign fpage_idx    = PW'(req_fpage_r);

  assign sts.is_free   = req_action_r == ACT_FREE;
  assign sts.zero_req  = req_count_r == '0;
  assign sts.too_big   = EW'(req_count_r) > EW'(NUM_PAGES);
  assign sts.fpage_bad = EW'(req_fpage_r) >= EW'(NUM_PAGES);
  assign sts.clr_last  = addr_r == CW'(NUM_PAGES - 1);
  assign sts.found     = hit;
  assign sts.scan_end  = !rd_v_r && !addr_in_heap;
  assign sts.len_zero  = len_q_r == '0;
  assign sts.wlast     = wcnt_r == COUNT_W'(1);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = wp_r;
    bm_wdata  = cmd.mark_val;
    len_we    = 1'b0;
    len_waddr = fpage_idx;
    len_wdata = '0;
    if (cmd.clr) begin
      bm_we     = 1'b1;
      bm_waddr  = addr_r[PW-1:0];
      bm_wdata  = 1'b0;
      len_we    = 1'b1;
      len_waddr = addr_r[PW-1:0];
    end else if (cmd.mark) begin
      bm_we = 1'b1;
    end
    if (cmd.scan && hit) begin
      len_we    = 1'b1;
      len_waddr = found_at;
      len_wdata = req_count_r;
    end else if (cmd.len_take) begin
      len_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (rd_issue) begin
      bm_q_r <= bm_mem[addr_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (cmd.len_rd) begin
      len_q_r <= len_mem[fpage_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr_r <= '0;
        rd_v_r <= 1'b0;
      end else if (cmd.clr) begin
        addr_r <= addr_r + CW'(1);
      end else if (cmd.scan) begin
        rd_v_r <= rd_issue && !hit;
        if (rd_issue) begin
          addr_r <= addr_r + CW'(1);
        end
      end
      if (cmd.result) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action_r <= in_action;
      req_count_r  <= in_count;
      req_fpage_r  <= in_fpage;
      run_r        <= '0;
      len_r        <= '0;
    end
    if (rd_issue) begin
      rd_pg_r <= addr_r[PW-1:0];
    end
    if (cmd.scan && rd_v_r) begin
      if (!bm_q_r) begin
        if (run_r == '0) begin
          run_start_r <= rd_pg_r;
        end
        run_r <= run_inc;
      end else begin
        run_r <= '0;
      end
    end
    if (cmd.scan && hit) begin
      at_r   <= found_at;
      wp_r   <= found_at;
      wcnt_r <= req_count_r;
    end else if (cmd.len_take) begin
      len_r  <= len_q_r;
      wp_r   <= fpage_idx;
      wcnt_r <= len_q_r;
    end else if (cmd.mark) begin
      wp_r   <= wp_r + PW'(1);
      wcnt_r <= wcnt_r - COUNT_W'(1);
    end
    if (cmd.result) begin
      case (cmd.res_kind)
        RES_ALLOC_OK: begin
          out_status_r   <= ST_OK;
          out_start_r    <= START_W'(at_r);
          out_released_r <= '0;
        end
        RES_NOSPC: begin
          out_status_r   <= ST_NOSPC;
          out_start_r    <= '0;
          out_released_r <= '0;
        end
        RES_ZERO: begin
          out_status_r   <= ST_ZERO;
          out_start_r    <= '0;
          out_released_r <= '0;
        end
        default: begin
          out_status_r   <= ST_OK;
          out_start_r    <= '0;
          out_released_r <= RELEASED_W'(len_r);
        end
      endcase
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_status   = out_status_r;
  assign out_start    = out_start_r;
  assign out_released = out_released_r;

endmodule

@@ hw/rtl/ffpa_ctrl.sv @@
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DECODE   = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_FREE_RD  = 3'd4;
  localparam logic [2:0] S_FREE_LEN = 3'd5;
  localparam logic [2:0] S_WRITE    = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] kind_r;
  logic [1:0] kind_nxt;
  logic       mval_r;
  logic       mval_nxt;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    mval_nxt     = mval_r;
    cmd          = '0;
    cmd.res_kind = kind_r;
    cmd.mark_val = mval_r;
    in_tready    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_free) begin
          kind_nxt  = RES_FREE;
          mval_nxt  = 1'b0;
          state_nxt = sts.fpage_bad ? S_RESP : S_FREE_RD;
        end else if (sts.zero_req) begin
          kind_nxt  = RES_ZERO;
          state_nxt = S_RESP;
        end else if (sts.too_big) begin
          kind_nxt  = RES_NOSPC;
          state_nxt = S_RESP;
        end else begin
          kind_nxt  = RES_ALLOC_OK;
          mval_nxt  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_nxt = S_WRITE;
        end else if (sts.scan_end) begin
          kind_nxt  = RES_NOSPC;
          state_nxt = S_RESP;
        end
      end
      S_FREE_RD: begin
        cmd.len_rd = 1'b1;
        state_nxt  = S_FREE_LEN;
      end
      S_FREE_LEN: begin
        cmd.len_take = 1'b1;
        state_nxt    = sts.len_zero ? S_RESP : S_WRITE;
      end
      S_WRITE: begin
        cmd.mark = 1'b1;
        if (sts.wlast) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      kind_r  <= RES_ZERO;
      mval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      mval_r  <= mval_nxt;
    end
  end

endmodule

@@ hw/rtl/first_fit_page_allocator_core.sv @@
// First-fit page allocator over NUM_PAGES pages. A request with in_tuser = 0
// allocates in_tdata[10:0] pages and answers with the lowest start page of a
// free run that is long enough; in_tuser = 1 frees the allocation that starts
// at in_tdata[20:11] and answers with the number of pages released. One
// request is handled at a time. After reset the block clears its page bitmap
// and length table before it raises in_tready. An allocate passes through
// decode, then scans the bitmap one page per cycle through a registered read
// until a free run is long enough or the last page has been examined, then
// marks the pages of the run one per cycle and posts the response. A free
// reads the length table, takes the length, clears each page released and
// posts the response. Rejected, zero-page and out-of-range free requests go
// from decode to the response. A response still waiting on out_tready holds off the next post.
module first_fit_page_allocator_core
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // page_count[10:0], free_page[20:11], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // start_page[9:0], pages_released[20:10], zero pad
  output logic [1:0]  out_tuser   // status
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [STATUS_W-1:0]   status;
  logic [START_W-1:0]    start_page;
  logic [RELEASED_W-1:0] pages_released;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffpa_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_tuser),
    .in_count     (in_tdata[10:0]),
    .in_fpage     (in_tdata[20:11]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_status   (status),
    .out_start    (start_page),
    .out_released (pages_released)
  );

  assign out_tdata = {3'b000, pages_released, start_page};
  assign out_tuser = status;

endmodule

@@ tb/page_alloc_checker.sv @@
`timescale 1ns / 1ps

module page_alloc_checker
  import ffpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [START_W-1:0]    start_page;
    logic [RELEASED_W-1:0] released;
  } alloc_resp_t;

  bit                 page_busy [NUM_PAGES];
  logic [COUNT_W-1:0] run_length [NUM_PAGES];
  alloc_resp_t        pending_resp [$];

  function automatic alloc_resp_t apply_request(logic act, logic [COUNT_W-1:0] count,
                                                logic [FPAGE_W-1:0] fpage);
    alloc_resp_t resp;
    int          run;
    int          run_start;
    int          at;
    int          len;
    bit          found;
    resp = '{ST_OK, '0, '0};
    if (act == ACT_ALLOC) begin
      if (count == '0) begin
        resp.status = ST_ZERO;
      end else begin
        run = 0;
        run_start = 0;
        at = 0;
        found = 1'b0;
        if (count <= NUM_PAGES) begin
          for (int p = 0; p < NUM_PAGES && !found; p++) begin
            if (page_busy[p]) begin
              run = 0;
            end else begin
              if (run == 0) run_start = p;
              run++;
              if (run >= count) begin
                found = 1'b1;
                at = run_start;
              end
            end
          end
        end
        if (!found) begin
          resp.status = ST_NOSPC;
        end else begin
          for (int k = 0; k < count; k++) page_busy[at + k] = 1'b1;
          run_length[at] = count;
          resp.start_page = at[START_W-1:0];
        end
      end
    end else if (fpage < NUM_PAGES) begin
      len = run_length[fpage];
      if (len > NUM_PAGES - int'(fpage)) len = NUM_PAGES - int'(fpage);
      for (int k = 0; k < len; k++) page_busy[fpage + k] = 1'b0;
      run_length[fpage] = '0;
      resp.released = len[RELEASED_W-1:0];
    end
    return resp;
  endfunction

  always @(posedge clk) begin
    alloc_resp_t want;
    int          bad;
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAGES; p++) begin
        page_busy[p] = 1'b0;
        run_length[p] = '0;
      end
      pending_resp.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      bad = 0;
      if (out_tvalid && out_tready) begin
        if (pending_resp.size() == 0) begin
          $display("%0t: unexpected response: status %0d start %0d released %0d", $time,
                   out_tuser, out_tdata[9:0], out_tdata[20:10]);
          bad++;
        end else begin
          want = pending_resp.pop_front();
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_tuser);
            bad++;
          end
          if (out_tdata[9:0] !== want.start_page) begin
            $display("%0t: start_page expected %0d, got %0d", $time, want.start_page,
                     out_tdata[9:0]);
            bad++;
          end
          if (out_tdata[20:10] !== want.released) begin
            $display("%0t: pages_released expected %0d, got %0d", $time, want.released,
                     out_tdata[20:10]);
            bad++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_resp.push_back(apply_request(in_tuser, in_tdata[10:0], in_tdata[20:11]));
      end
      errors <= errors + bad;
      outstanding <= pending_resp.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import ffpa_pkg::*;
();

  localparam int NUM_PAGES    = 1024;
  localparam int RANDOM_ITEMS = 555;
  localparam int CYCLE_LIMIT  = 6_000_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tready = 1'b0;
  logic        quiet      = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;
  wire  [1:0]  out_tuser;
  int          errors;
  int          outstanding;
  int          ready_left = 0;
  int          cycles     = 0;
  logic        action_q [$];
  logic [9:0]  live_q [$];

  always #6 clk = ~clk;

  first_fit_page_allocator_core #(
    .NUM_PAGES(NUM_PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  page_alloc_checker #(
    .NUM_PAGES(NUM_PAGES)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (errors),
    .outstanding(outstanding)
  );

  function automatic int pick_idle();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [10:0] pick_pages();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 11'($urandom_range(1, 8));
    if (r < 90) return 11'($urandom_range(9, 64));
    if (r < 98) return 11'($urandom_range(65, 256));
    return 11'($urandom_range(257, NUM_PAGES));
  endfunction

  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (quiet) begin
      out_tready <= 1'b1;
      ready_left <= 16;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_left <= pick_idle();
    end else begin
      out_tready <= 1'b1;
      ready_left <= ($urandom_range(99) < 70) ? $urandom_range(0, 6) : $urandom_range(20, 200);
    end
  end

  // track granted start pages; sampled at the falling edge ahead of the handshake edge
  always @(negedge clk) begin
    logic act;
    if (rst_n && out_tvalid && out_tready && action_q.size() != 0) begin
      act = action_q.pop_front();
      if (act == ACT_ALLOC && out_tuser == ST_OK) live_q.push_back(out_tdata[9:0]);
    end
    if (rst_n && in_tvalid && in_tready) action_q.push_back(in_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_request(input logic act, input logic [10:0] count,
                              input logic [9:0] fpage);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {3'b000, fpage, count};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = (quiet || $urandom_range(99) < 45) ? 0 : pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_alloc(input logic [10:0] count);
    send_request(ACT_ALLOC, count, 10'($urandom_range(1023)));
  endtask

  task automatic send_free(input logic [9:0] page);
    send_request(ACT_FREE, 11'($urandom_range(2047)), page);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    int idx;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_alloc(11'd0);
    send_alloc(11'd1024);
    send_alloc(11'd1);
    send_free(10'd0);
    send_alloc(11'd1025);
    send_alloc(11'd2047);
    send_alloc(11'd1);
    send_alloc(11'd3);
    send_alloc(11'd2);
    send_free(10'd1);
    send_free(10'd1);
    send_free(10'd5);
    send_free(10'd1023);
    send_alloc(11'd2);
    send_alloc(11'd1018);
    send_alloc(11'd1);
    send_alloc(11'd1);
    send_free(10'd6);
    send_free(10'd1023);
    send_free(10'd0);
    send_free(10'd1);
    send_free(10'd3);
    send_free(10'd4);
    drain();
    live_q.delete();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= (i >= 200 && i < 260);
      if (i % 100 == 99) drain();
      r = $urandom_range(99);
      if (r < 52) begin
        send_alloc(pick_pages());
      end else if (r < 85 && live_q.size() != 0) begin
        idx = $urandom_range(live_q.size() - 1);
        r = live_q[idx];
        live_q.delete(idx);
        send_free(r[9:0]);
      end else if (r < 93) begin
        send_free(10'($urandom_range(1023)));
      end else begin
        case ($urandom_range(2))
          0: send_alloc(11'd0);
          1: send_alloc(11'($urandom_range(1025, 2047)));
          default: send_alloc(11'd1024);
        endcase
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
